FILE: src/wlpc_pkg.sv
// Shared types, register indexes and constants of the white lane pixel classifier.
// Depends on nothing; every other file of the block imports it.
package wlpc_pkg;

    localparam int COUNT_BITS = 21;

    localparam logic [1:0] REG_SENS_MODE    = 2'd0;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic [1:0] SENS_MODE_130   = 2'd0;
    localparam logic [1:0] SENS_MODE_115   = 2'd1;
    localparam logic [1:0] SENS_MODE_70    = 2'd2;
    // spare code, behaves as SENS_MODE_70
    localparam logic [1:0] SENS_MODE_SPARE = 2'd3;

    // white needs V above 255 - sensitivity
    localparam logic [7:0] V_FLOOR_130 = 8'd125;
    localparam logic [7:0] V_FLOOR_115 = 8'd140;
    localparam logic [7:0] V_FLOOR_70  = 8'd185;

    // S < 70 with S = round(255*d/V) is 510*d < 139*V
    localparam logic [9:0] SAT_D_GAIN = 10'd510;
    localparam logic [7:0] SAT_V_GAIN = 8'd139;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic band_white;
        logic raw_white;
        logic frame_end;
        logic out_of_lane;
    } result_t;

    typedef struct packed {
        logic in_band;
        logic in_win;
        logic frame_end;
    } pos_flags_t;

    // floor(x/5) for every 16-bit x
    function automatic logic [15:0] div_by_5(input logic [15:0] x);
        logic [32:0] p;
        p = 33'(x) * 33'd52429;
        return 16'(p >> 18);
    endfunction

    // floor(x/3) for every 16-bit x
    function automatic logic [15:0] div_by_3(input logic [15:0] x);
        logic [32:0] p;
        p = 33'(x) * 33'd43691;
        return 16'(p >> 17);
    endfunction

endpackage

FILE: src/wlpc_cfg_regs.sv
// Configuration registers plus the row and column bounds and window area derived from them.
// Depends on wlpc_pkg.
module wlpc_cfg_regs
    import wlpc_pkg::*;
#(
    parameter int DIM_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [DIM_BITS-1:0]   cfg_data,
    output logic [1:0]            sens_mode,
    output logic [DIM_BITS-1:0]   frame_width,
    output logic [DIM_BITS-1:0]   frame_height,
    output logic [DIM_BITS-1:0]   band_row0,
    output logic [DIM_BITS-1:0]   win_row0,
    output logic [DIM_BITS-1:0]   win_row1,
    output logic [DIM_BITS-1:0]   win_col0,
    output logic [DIM_BITS-1:0]   win_col1,
    output logic [2*DIM_BITS-1:0] win_area
);

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

    logic [1:0]            mode_reg,   mode_next;
    logic [DIM_BITS-1:0]   width_reg,  width_next;
    logic [DIM_BITS-1:0]   height_reg, height_next;
    logic [DIM_BITS-1:0]   band0_reg, r0_reg, r1_reg, c0_reg, c1_reg;
    logic [2*DIM_BITS-1:0] area_reg;
    logic [15:0]           band0_q, r0_q, r1_q, c0_q, c1_q;
    logic [15:0]           band0_rst, r0_rst, r1_rst, c0_rst, c1_rst;
    logic [DIM_BITS-1:0]   row_span, col_span;

    always_comb
    begin
        mode_next   = mode_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SENS_MODE:    mode_next   = cfg_data[1:0];
                REG_FRAME_WIDTH:  width_next  = cfg_data;
                REG_FRAME_HEIGHT: height_next = cfg_data;
                default:          mode_next   = mode_reg;
            endcase
        end
    end

    assign band0_q = div_by_5(16'(32'(height_next) * 32'd2));
    assign r0_q    = div_by_5(16'(32'(height_next) * 32'd3));
    assign r1_q    = div_by_5(16'(32'(height_next) * 32'd4));
    assign c0_q    = div_by_3(16'(width_next));
    assign c1_q    = div_by_3(16'(32'(width_next) * 32'd2));

    assign band0_rst = div_by_5(16'(32'(HEIGHT_RESET) * 32'd2));
    assign r0_rst    = div_by_5(16'(32'(HEIGHT_RESET) * 32'd3));
    assign r1_rst    = div_by_5(16'(32'(HEIGHT_RESET) * 32'd4));
    assign c0_rst    = div_by_3(16'(WIDTH_RESET));
    assign c1_rst    = div_by_3(16'(32'(WIDTH_RESET) * 32'd2));

    assign row_span = r1_reg - r0_reg;
    assign col_span = c1_reg - c0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= SENS_MODE_130;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            band0_reg  <= band0_rst[DIM_BITS-1:0];
            r0_reg     <= r0_rst[DIM_BITS-1:0];
            r1_reg     <= r1_rst[DIM_BITS-1:0];
            c0_reg     <= c0_rst[DIM_BITS-1:0];
            c1_reg     <= c1_rst[DIM_BITS-1:0];
            area_reg   <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            band0_reg  <= band0_q[DIM_BITS-1:0];
            r0_reg     <= r0_q[DIM_BITS-1:0];
            r1_reg     <= r1_q[DIM_BITS-1:0];
            c0_reg     <= c0_q[DIM_BITS-1:0];
            c1_reg     <= c1_q[DIM_BITS-1:0];
            area_reg   <= (2*DIM_BITS)'(row_span) * (2*DIM_BITS)'(col_span);
        end
    end

    assign sens_mode    = mode_reg;
    assign frame_width  = width_reg;
    assign frame_height = height_reg;
    assign band_row0    = band0_reg;
    assign win_row0     = r0_reg;
    assign win_row1     = r1_reg;
    assign win_col0     = c0_reg;
    assign win_col1     = c1_reg;
    assign win_area     = area_reg;

endmodule

FILE: src/wlpc_raster_cnt.sv
// Raster position counters and the band, window and frame-end flags of the current pixel.
// Depends on wlpc_pkg.
module wlpc_raster_cnt
    import wlpc_pkg::*;
#(
    parameter int DIM_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [DIM_BITS-1:0] frame_width,
    input  logic [DIM_BITS-1:0] frame_height,
    input  logic [DIM_BITS-1:0] band_row0,
    input  logic [DIM_BITS-1:0] win_row0,
    input  logic [DIM_BITS-1:0] win_row1,
    input  logic [DIM_BITS-1:0] win_col0,
    input  logic [DIM_BITS-1:0] win_col1,
    output pos_flags_t          flags
);

    logic [DIM_BITS-1:0] row_reg, row_next;
    logic [DIM_BITS-1:0] col_reg, col_next;
    logic [DIM_BITS:0]   col_plus, row_plus;
    logic                row_end;

    assign col_plus = (DIM_BITS+1)'(col_reg) + 1'b1;
    assign row_plus = (DIM_BITS+1)'(row_reg) + 1'b1;
    assign row_end  = col_plus >= {1'b0, frame_width};

    assign flags.frame_end = row_end && (row_plus >= {1'b0, frame_height});
    assign flags.in_band   = (row_reg >= band_row0) && (row_reg < win_row1);
    assign flags.in_win    = (row_reg >= win_row0) && (row_reg < win_row1)
                           && (col_reg >= win_col0) && (col_reg < win_col1);

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (advance)
        begin
            priority if (flags.frame_end)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (row_end)
            begin
                row_next = row_plus[DIM_BITS-1:0];
                col_next = '0;
            end
            else
            begin
                col_next = col_plus[DIM_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

FILE: src/wlpc_white_test.sv
// HSV white test of one BGR pixel: V = max, saturation below 70, V above the mode floor.
// Depends on wlpc_pkg.
module wlpc_white_test
    import wlpc_pkg::*;
(
    input  pixel_t     pixel,
    input  logic [1:0] sens_mode,
    output logic       white
);

    logic [7:0]  v_max, v_min, v_floor;
    logic [16:0] d_term;
    logic [16:0] v_term;

    always_comb
    begin
        v_max = pixel.blue;
        v_min = pixel.blue;
        if (pixel.green > v_max) v_max = pixel.green;
        if (pixel.red > v_max)   v_max = pixel.red;
        if (pixel.green < v_min) v_min = pixel.green;
        if (pixel.red < v_min)   v_min = pixel.red;
    end

    always_comb
    begin
        unique case (sens_mode)
            SENS_MODE_130: v_floor = V_FLOOR_130;
            SENS_MODE_115: v_floor = V_FLOOR_115;
            default:       v_floor = V_FLOOR_70;
        endcase
    end

    assign d_term = 17'(v_max - v_min) * 17'(SAT_D_GAIN);
    assign v_term = 17'(v_max) * 17'(SAT_V_GAIN);
    assign white  = (d_term < v_term) && (v_max > v_floor);

endmodule

FILE: src/white_lane_pixel_classifier.sv
// Top level of the white lane pixel classifier: input register, white test, window count,
// result register. Depends on wlpc_pkg, wlpc_cfg_regs, wlpc_raster_cnt, wlpc_white_test.
//
//  channel  handshake            word
//  pix      pix_valid/pix_stall  pixel_t  (blue, green, red)
//  res      res_valid/res_stall  result_t (band_white, raw_white, frame_end, out_of_lane)
//  cfg      cfg_write            cfg_index, cfg_data
//
// One word per cycle while res_stall is low; a taken pixel waits in the pixel stage, its
// result word is then registered in the result stage and handed off from there.
// Pixel stage and result stage each hold one word; pix_stall rises only when both are full
// and res_stall is high.
// Reset clears counters, valids and loads the default 640x480 frame, mode 0.
module white_lane_pixel_classifier
    import wlpc_pkg::*;
#(
    parameter int DIM_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    output logic                pix_stall,
    input  pixel_t              pix,
    output logic                res_valid,
    input  logic                res_stall,
    output result_t             res,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [DIM_BITS-1:0] cfg_data
);

    localparam int LANE_BITS = COUNT_BITS + 5;
    localparam int CMP_BITS  = (LANE_BITS > 2*DIM_BITS) ? LANE_BITS : 2*DIM_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [1:0]            sens_mode;
    logic [DIM_BITS-1:0]   frame_width, frame_height;
    logic [DIM_BITS-1:0]   band_row0, win_row0, win_row1, win_col0, win_col1;
    logic [2*DIM_BITS-1:0] win_area;

    pos_flags_t            flags;
    logic                  pix_accept, out_ready, s1_advance, white;

    logic                  s1_valid_reg;
    pixel_t                s1_pix_reg;
    pos_flags_t            s1_flags_reg;
    logic                  res_valid_reg;
    result_t               res_reg, res_next;
    logic [COUNT_BITS-1:0] count_reg, count_next, count_bumped;
    logic [CMP_BITS-1:0]   count_x20;

    wlpc_cfg_regs #(.DIM_BITS(DIM_BITS)) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sens_mode    (sens_mode),
        .frame_width  (frame_width),
        .frame_height (frame_height),
        .band_row0    (band_row0),
        .win_row0     (win_row0),
        .win_row1     (win_row1),
        .win_col0     (win_col0),
        .win_col1     (win_col1),
        .win_area     (win_area)
    );

    wlpc_raster_cnt #(.DIM_BITS(DIM_BITS)) u_raster (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (pix_accept),
        .frame_width  (frame_width),
        .frame_height (frame_height),
        .band_row0    (band_row0),
        .win_row0     (win_row0),
        .win_row1     (win_row1),
        .win_col0     (win_col0),
        .win_col1     (win_col1),
        .flags        (flags)
    );

    wlpc_white_test u_white (
        .pixel     (s1_pix_reg),
        .sens_mode (sens_mode),
        .white     (white)
    );

    assign out_ready  = !res_valid_reg || !res_stall;
    assign pix_stall  = s1_valid_reg && !out_ready;
    assign pix_accept = pix_valid && !pix_stall;
    assign s1_advance = s1_valid_reg && out_ready;

    always_comb
    begin
        count_bumped = count_reg;
        if (white && s1_flags_reg.in_win && (count_reg != COUNT_MAX))
            count_bumped = count_reg + 1'b1;
        count_x20 = (CMP_BITS'(count_bumped) << 4) + (CMP_BITS'(count_bumped) << 2);

        res_next.band_white  = white && s1_flags_reg.in_band;
        res_next.raw_white   = white;
        res_next.frame_end   = s1_flags_reg.frame_end;
        res_next.out_of_lane = s1_flags_reg.frame_end && (count_x20 > CMP_BITS'(win_area));

        count_next = s1_flags_reg.frame_end ? '0 : count_bumped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (!s1_valid_reg || out_ready)
                s1_valid_reg <= pix_accept;
            if (out_ready)
                res_valid_reg <= s1_valid_reg;
            if (s1_advance)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_pix_reg   <= pix;
            s1_flags_reg <= flags;
        end
        if (s1_advance)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: tb/sv/white_lane_pixel_classifier_checker.sv
`timescale 1ns / 100ps
// Checker for white_lane_pixel_classifier: follows register writes and accepted pixels,
// predicts each result word and compares it with what the result channel delivers.
// Depends on wlpc_pkg for the word types and register indexes.
module white_lane_pixel_classifier_checker
    import wlpc_pkg::*;
#(
    parameter int DIM_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    input  logic                pix_stall,
    input  pixel_t              pix,
    input  logic                res_valid,
    input  logic                res_stall,
    input  result_t             res,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [DIM_BITS-1:0] cfg_data,
    output int                  errors,
    output int                  pending,
    output int                  results,
    output int                  frames,
    output int                  lane_flags
);

    localparam int SAT_LIMIT    = 70;
    localparam int V_TOP        = 255;
    localparam int SENS_WIDE    = 130;
    localparam int SENS_MID     = 115;
    localparam int SENS_NARROW  = 70;
    localparam int LANE_RATIO   = 20;
    localparam int REPORT_LIMIT = 10;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [1:0]            sens_mode;
    logic [DIM_BITS-1:0]   frame_w;
    logic [DIM_BITS-1:0]   frame_h;
    logic [DIM_BITS-1:0]   row_idx;
    logic [DIM_BITS-1:0]   col_idx;
    logic [COUNT_BITS-1:0] window_count;
    result_t               expected_q[$];
    result_t               want;
    int                    mismatches;
    int                    checked;
    int                    frames_done;
    int                    flags_seen;

    function automatic result_t classify_pixel(input pixel_t px);
        result_t word;
        int      peak;
        int      trough;
        int      sat;
        int      sens;
        int      w;
        int      h;
        int      row;
        int      col;
        int      band_lo;
        int      win_lo;
        int      win_hi;
        int      col_lo;
        int      col_hi;
        logic    white;
        logic    in_band;
        logic    in_win;
        logic    row_end;
        logic    last;
        peak   = px.blue;
        trough = px.blue;
        if (px.green > peak) peak = px.green;
        if (px.red > peak) peak = px.red;
        if (px.green < trough) trough = px.green;
        if (px.red < trough) trough = px.red;
        sat = (peak == 0) ? 0 : (510 * (peak - trough) + peak) / (2 * peak);
        case (sens_mode)
            SENS_MODE_130: sens = SENS_WIDE;
            SENS_MODE_115: sens = SENS_MID;
            default:       sens = SENS_NARROW;
        endcase
        white   = sat < SAT_LIMIT && peak > V_TOP - sens;
        w       = frame_w;
        h       = frame_h;
        row     = row_idx;
        col     = col_idx;
        band_lo = h * 2 / 5;
        win_lo  = h * 3 / 5;
        win_hi  = h * 4 / 5;
        col_lo  = w / 3;
        col_hi  = w * 2 / 3;
        in_band = row >= band_lo && row < win_hi;
        in_win  = row >= win_lo && row < win_hi && col >= col_lo && col < col_hi;
        row_end = col + 1 >= w;
        last    = row_end && row + 1 >= h;
        if (white && in_win && window_count != COUNT_MAX) window_count++;
        word.band_white  = white && in_band;
        word.raw_white   = white;
        word.frame_end   = last;
        word.out_of_lane = last
            && (LANE_RATIO * int'(window_count) > (win_hi - win_lo) * (col_hi - col_lo));
        if (last)
        begin
            window_count = '0;
            row_idx      = '0;
            col_idx      = '0;
        end
        else if (row_end)
        begin
            col_idx = '0;
            row_idx++;
        end
        else
        begin
            col_idx++;
        end
        return word;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_mode    = SENS_MODE_130;
            frame_w      = DIM_BITS'(640);
            frame_h      = DIM_BITS'(480);
            row_idx      = '0;
            col_idx      = '0;
            window_count = '0;
            expected_q.delete();
            mismatches   = 0;
            checked      = 0;
            frames_done  = 0;
            flags_seen   = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                checked++;
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result word %0d arrived with nothing expected: %b %b %b %b",
                                 checked, res.band_white, res.raw_white, res.frame_end,
                                 res.out_of_lane);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (res.band_white !== want.band_white || res.raw_white !== want.raw_white
                        || res.frame_end !== want.frame_end
                        || res.out_of_lane !== want.out_of_lane)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("result word %0d expected %b %b %b %b, got %b %b %b %b",
                                     checked, want.band_white, want.raw_white, want.frame_end,
                                     want.out_of_lane, res.band_white, res.raw_white,
                                     res.frame_end, res.out_of_lane);
                    end
                    if (want.frame_end) frames_done++;
                    if (want.out_of_lane) flags_seen++;
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SENS_MODE:    sens_mode = cfg_data[1:0];
                    REG_FRAME_WIDTH:  frame_w   = cfg_data;
                    REG_FRAME_HEIGHT: frame_h   = cfg_data;
                    default:          ;
                endcase
            end
            if (pix_valid && !pix_stall)
                expected_q.push_back(classify_pixel(pix));
        end
        errors     <= mismatches;
        pending    <= expected_q.size();
        results    <= checked;
        frames     <= frames_done;
        lane_flags <= flags_seen;
    end

endmodule

FILE: tb/sv/white_lane_pixel_classifier_tb.sv
`timescale 1ns / 100ps
// Testbench top for white_lane_pixel_classifier: writes frame settings, streams pixels,
// stalls the result side at random and prints the verdict.
// Depends on wlpc_pkg, the block and white_lane_pixel_classifier_checker.
module white_lane_pixel_classifier_tb;
    import wlpc_pkg::*;

    localparam int DIM_BITS      = 12;
    localparam int RANDOM_PIXELS = 1250;
    localparam int IDLE_PCT      = 18;
    localparam int QUIET_FROM    = 450;
    localparam int QUIET_TO      = 750;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                pix_valid;
    logic                pix_stall;
    pixel_t              pix;
    logic                res_valid;
    logic                res_stall = 1'b0;
    result_t             res;
    logic                cfg_write;
    logic [1:0]          cfg_index;
    logic [DIM_BITS-1:0] cfg_data;
    logic                quiet;
    int                  errors;
    int                  pending;
    int                  results;
    int                  frames;
    int                  lane_flags;
    int                  cycle_count = 0;
    int                  pixels_sent;
    int                  settings;

    pixel_t probe_pixels[12] = '{
        '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd0,   8'd0},
        '{8'd0,   8'd255, 8'd0},   '{8'd0,   8'd0,   8'd255}, '{8'd125, 8'd125, 8'd125},
        '{8'd126, 8'd126, 8'd126}, '{8'd255, 8'd186, 8'd255}, '{8'd255, 8'd185, 8'd255},
        '{8'd186, 8'd255, 8'd220}, '{8'd200, 8'd200, 8'd200}, '{8'd255, 8'd255, 8'd255}
    };

    white_lane_pixel_classifier #(.DIM_BITS(DIM_BITS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    white_lane_pixel_classifier_checker #(.DIM_BITS(DIM_BITS)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix        (pix),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .errors     (errors),
        .pending    (pending),
        .results    (results),
        .frames     (frames),
        .lane_flags (lane_flags)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        res_stall   <= !quiet && $urandom_range(0, 99) < IDLE_PCT;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic pixel_t make_pixel(input int white_pct);
        logic [7:0] chan[3];
        int         peak;
        int         spread;
        int         hi;
        int         lo;
        if ($urandom_range(0, 99) >= white_pct) return pixel_t'(24'($urandom));
        peak   = $urandom_range(100, 255);
        spread = $urandom_range(0, peak * 3 / 10);
        hi     = $urandom_range(0, 2);
        lo     = (hi + 1 + $urandom_range(0, 1)) % 3;
        foreach (chan[k]) chan[k] = 8'(peak - $urandom_range(0, spread));
        chan[hi] = 8'(peak);
        chan[lo] = 8'(peak - spread);
        return '{chan[0], chan[1], chan[2]};
    endfunction

    task automatic send_pixel(input pixel_t word);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= word;
        do
            @(posedge clk);
        while (pix_stall);
        pixels_sent++;
    endtask

    // drop valid and hold until every word is back
    task automatic drain();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame(input logic [1:0] mode, input int width, input int height);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= REG_SENS_MODE;
        cfg_data  <= DIM_BITS'(mode);
        @(posedge clk);
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= DIM_BITS'(width);
        @(posedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= DIM_BITS'(height);
        @(posedge clk);
        cfg_write <= 1'b0;
        settings++;
    endtask

    initial
    begin
        logic [1:0] mode;
        int         width;
        int         height;
        int         count;
        int         white_pct;
        int         random_sent;
        rst_n       = 1'b0;
        pix_valid   = 1'b0;
        pix         = '0;
        cfg_write   = 1'b0;
        cfg_index   = REG_SENS_MODE;
        cfg_data    = '0;
        quiet       = 1'b0;
        pixels_sent = 0;
        settings    = 0;
        random_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_frame(SENS_MODE_130, 3, 5);
        foreach (probe_pixels[i]) send_pixel(probe_pixels[i]);
        set_frame(SENS_MODE_115, 3, 5);
        send_pixel('{8'd140, 8'd140, 8'd140});
        send_pixel('{8'd141, 8'd141, 8'd141});
        set_frame(SENS_MODE_70, 3, 5);
        send_pixel('{8'd185, 8'd185, 8'd185});
        send_pixel('{8'd186, 8'd186, 8'd186});
        set_frame(SENS_MODE_SPARE, 3, 5);
        send_pixel('{8'd185, 8'd185, 8'd185});
        send_pixel('{8'd186, 8'd186, 8'd186});
        set_frame(SENS_MODE_130, 4095, 4095);
        repeat (3) send_pixel('{8'd255, 8'd255, 8'd255});
        set_frame(SENS_MODE_SPARE, 0, 0);
        repeat (2) send_pixel('{8'd255, 8'd250, 8'd245});

        while (random_sent < RANDOM_PIXELS)
        begin
            mode = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0:
                begin
                    width  = $urandom_range(0, 2);
                    height = $urandom_range(0, 4);
                end
                1:
                begin
                    width  = $urandom_range(25, 90);
                    height = $urandom_range(5, 8);
                end
                default:
                begin
                    width  = $urandom_range(3, 24);
                    height = $urandom_range(5, 16);
                end
            endcase
            case ($urandom_range(0, 4))
                0:       white_pct = 0;
                1:       white_pct = 3;
                2:       white_pct = 40;
                3:       white_pct = 85;
                default: white_pct = 100;
            endcase
            count = $urandom_range(8, 160);
            if (count > RANDOM_PIXELS - random_sent)
                count = RANDOM_PIXELS - random_sent;
            set_frame(mode, width, height);
            repeat (count)
            begin
                quiet <= random_sent >= QUIET_FROM && random_sent < QUIET_TO;
                send_pixel(make_pixel(white_pct));
                random_sent++;
            end
        end
        quiet <= 1'b0;
        drain();

        $display("%0d pixels sent, %0d result words checked, %0d frames closed, %0d out of lane",
                 pixels_sent, results, frames, lane_flags);
        $display("%0d frame settings, all four modes, sizes 0x0 up to 4095x4095", settings);
        if (pending != 0)
            $display("%0d result words never arrived", pending);
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
